FILE: hdl/rpm_pkg.sv
// Shared types and constants for the reachability path matrix block.
`default_nettype none

package rpm_pkg;

    localparam int VCOUNT_W = 5;
    localparam int VERTEX_W = 4;
    localparam int ROW_W    = 16;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_CLOSURE = 1'b1;

    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic load_edge;
        logic reject;
        logic init_row;
        logic step_row;
        logic emit_row;
    } t_dp_cmd;

    typedef struct packed {
        logic edge_bad;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hdl/rpm_datapath.sv
// Datapath: adjacency, power and closure rows, vertex count and result register.
`default_nettype none

module rpm_datapath import rpm_pkg::*; #(
    parameter int ROWS = 16,
    parameter int IW   = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [VCOUNT_W-1:0] i_cfg_vertex_count,
    input  wire logic [VERTEX_W-1:0] i_src_vertex,
    input  wire logic [VERTEX_W-1:0] i_dst_vertex,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [IW-1:0]       i_row,
    output t_dp_stat                 o_stat,
    output logic [IW-1:0]            o_n_last,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_kind,
    output logic [VERTEX_W-1:0]      o_row_index,
    output logic [ROW_W-1:0]         o_reach_bits,
    output logic                     o_last
);

    logic [VCOUNT_W-1:0] r_vcount;
    logic [ROW_W-1:0]    r_adj [ROWS];
    logic [ROW_W-1:0]    r_pow [ROWS];
    logic [ROW_W-1:0]    r_clo [ROWS];
    logic                r_out_valid;
    logic                r_kind;
    logic [VERTEX_W-1:0] r_row_index;
    logic [ROW_W-1:0]    r_reach;
    logic                r_last;

    logic [VCOUNT_W-1:0] n_eff;
    logic [ROW_W-1:0]    col_mask;
    logic [ROW_W-1:0]    init_val;
    logic [ROW_W-1:0]    step_val;
    logic [ROW_W-1:0]    pow_sel;
    logic [IW-1:0]       src_idx;

    assign o_cfg_ready = 1'b1;
    assign src_idx     = i_src_vertex[IW-1:0];

    always_comb begin
        if (r_vcount == '0) begin
            n_eff = VCOUNT_W'(1);
        end else if (r_vcount > VCOUNT_W'(ROWS)) begin
            n_eff = VCOUNT_W'(ROWS);
        end else begin
            n_eff = r_vcount;
        end
    end

    assign o_n_last = IW'(n_eff - VCOUNT_W'(1));

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            col_mask[j] = (VCOUNT_W'(j) < n_eff);
        end
    end

    assign init_val = r_adj[i_row] & col_mask;
    assign pow_sel  = r_pow[i_row];

    always_comb begin
        step_val = '0;
        for (int k = 0; k < ROWS; k++) begin
            if (pow_sel[k]) begin
                step_val = step_val | r_adj[k];
            end
        end
        step_val = step_val & col_mask;
    end

    assign o_stat.edge_bad = ({1'b0, i_src_vertex} >= n_eff) ||
                             ({1'b0, i_dst_vertex} >= n_eff);
    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= VCOUNT_RESET;
            r_out_valid <= 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                r_adj[r] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_vertex_count;
            end
            if (i_cmd.load_edge) begin
                r_adj[src_idx] <= r_adj[src_idx] | (ROW_W'(1) << i_dst_vertex);
            end
            if (i_cmd.reject || i_cmd.emit_row) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_row) begin
            r_pow[i_row] <= init_val;
            r_clo[i_row] <= init_val;
        end else if (i_cmd.step_row) begin
            r_pow[i_row] <= step_val;
            r_clo[i_row] <= r_clo[i_row] | step_val;
        end
        if (i_cmd.reject) begin
            r_kind      <= KIND_REJECT;
            r_row_index <= '0;
            r_reach     <= '0;
            r_last      <= 1'b1;
        end else if (i_cmd.emit_row) begin
            r_kind      <= KIND_ROW;
            r_row_index <= VERTEX_W'(i_row);
            r_reach     <= r_clo[i_row];
            r_last      <= (i_row == o_n_last);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_row_index  = r_row_index;
    assign o_reach_bits = r_reach;
    assign o_last       = r_last;

endmodule

`default_nettype wire

FILE: hdl/rpm_ctrl.sv
// Controller: sequences edge loads, closure passes and row emission.
`default_nettype none

module rpm_ctrl import rpm_pkg::*; #(
    parameter int IW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_op,
    input  wire t_dp_stat      i_stat,
    input  wire logic [IW-1:0] i_n_last,
    output t_dp_cmd            o_cmd,
    output logic [IW-1:0]      o_row
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INIT = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_row, n_row;
    logic [IW-1:0] r_pass, n_pass;
    logic          accept;
    logic          row_done;

    assign o_ready  = (r_state == S_IDLE) && i_stat.out_free;
    assign accept   = i_valid && o_ready;
    assign row_done = (r_row == i_n_last);
    assign o_row    = r_row;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_pass  = r_pass;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_row = '0;
                if (accept) begin
                    if (i_op == OP_CLOSURE) begin
                        n_state = S_INIT;
                    end else if (i_stat.edge_bad) begin
                        o_cmd.reject = 1'b1;
                    end else begin
                        o_cmd.load_edge = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_row = 1'b1;
                n_row          = r_row + IW'(1);
                n_pass         = IW'(1);
                if (row_done) begin
                    n_row   = '0;
                    n_state = (i_n_last == '0) ? S_EMIT : S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step_row = 1'b1;
                n_row          = r_row + IW'(1);
                if (row_done) begin
                    n_row = '0;
                    if (r_pass == i_n_last) begin
                        n_state = S_EMIT;
                    end else begin
                        n_pass = r_pass + IW'(1);
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_row = 1'b1;
                    n_row          = r_row + IW'(1);
                    if (row_done) begin
                        n_row   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_pass  <= n_pass;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/reachability_path_matrix.sv
// Top level: reachability path matrix from Boolean adjacency powers.
//
//  channel  | direction | handshake                 | beat
//  ---------+-----------+---------------------------+--------------------------------
//  config   | in        | i_cfg_valid / o_cfg_ready | vertex_count
//  item     | in        | i_valid / o_ready         | op, src_vertex, dst_vertex
//  result   | out       | o_valid / i_ready         | kind, row_index, reach_bits, last
//
//  An edge beat is loaded into the adjacency rows on accept; a rejected edge puts one beat in the result register.
//  A closure beat is accepted, then inits each row, then runs the row-step passes over all rows
//  (one shared row multiply unit over the adjacency rows) and emits one result beat per row;
//  the row count is the clamped vertex_count.
//  Synchronous active-low reset clears the adjacency rows and sets vertex_count to 16.
//  Backpressure on the result holds emission; o_ready stays low until the register frees.
`default_nettype none

module reachability_path_matrix import rpm_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [VCOUNT_W-1:0] i_cfg_vertex_count,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_op,
    input  wire logic [VERTEX_W-1:0] i_src_vertex,
    input  wire logic [VERTEX_W-1:0] i_dst_vertex,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_kind,
    output logic [VERTEX_W-1:0]      o_row_index,
    output logic [ROW_W-1:0]         o_reach_bits,
    output logic                     o_last
);

    localparam int ROWS = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
    localparam int IW   = $clog2(ROWS);

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [IW-1:0] row;
    logic [IW-1:0] n_last;

    rpm_ctrl #(
        .IW (IW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (i_op),
        .i_stat   (stat),
        .i_n_last (n_last),
        .o_cmd    (cmd),
        .o_row    (row)
    );

    rpm_datapath #(
        .ROWS (ROWS),
        .IW   (IW)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .i_src_vertex       (i_src_vertex),
        .i_dst_vertex       (i_dst_vertex),
        .i_cmd              (cmd),
        .i_row              (row),
        .o_stat             (stat),
        .o_n_last           (n_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_row_index        (o_row_index),
        .o_reach_bits       (o_reach_bits),
        .o_last             (o_last)
    );

endmodule

`default_nettype wire

FILE: hdl/rpm_checker.sv
// Port-level checks for the reachability path matrix, bound to the top level.
`default_nettype none

module rpm_checker import rpm_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_ready,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire logic                o_kind,
    input wire logic [VERTEX_W-1:0] o_row_index,
    input wire logic [ROW_W-1:0]    o_reach_bits,
    input wire logic                o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_row_index)
            && $stable(o_reach_bits) && $stable(o_last))
        else $error("result beat changed while stalled");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_REJECT |->
            o_last && o_row_index == '0 && o_reach_bits == '0)
        else $error("reject beat malformed");

    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ROW && !o_last |-> !o_ready)
        else $error("item accepted during row emission");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind reachability_path_matrix rpm_checker u_rpm_checker (.*);

`default_nettype wire
